>>> hdl/fscc_pkg.sv
// ----------------------------------------------------------------------------
// fscc_pkg
// Types and constants shared by the frame sequence continuity checker.
// ----------------------------------------------------------------------------
package fscc_pkg;

    // input item kinds
    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_ABSENT = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // result kinds
    localparam logic REPORT_FRAME   = 1'b0;
    localparam logic REPORT_SUMMARY = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_META_TYPE  = 2'd0;
    localparam logic [1:0] CFG_FRAME_TYPE = 2'd1;
    localparam logic [1:0] CFG_ITEM_SIZE  = 2'd2;

    // configuration reset values
    localparam logic [7:0]  META_TYPE_RESET  = 8'd8;
    localparam logic [15:0] FRAME_TYPE_RESET = 16'd1;
    localparam logic [7:0]  ITEM_SIZE_RESET  = 8'd4;

    // channel status codes
    typedef enum logic [1:0] {
        ST_PASS       = 2'd0,
        ST_BROKEN     = 2'd1,
        ST_INCOMPLETE = 2'd2,
        ST_MISSING    = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FRAME,
        S_P1,
        S_P2A,
        S_P2B,
        S_P3A,
        S_P3B
    } state_t;

    // one channel table entry
    typedef struct packed {
        logic [31:0]        frame_count;
        logic signed [31:0] start_id;
        logic signed [31:0] end_id;
        logic               good;
        logic               cont;
        logic               complete;
        status_t            status;
    } channel_entry_t;

    localparam int ENTRY_W = $bits(channel_entry_t);

    localparam channel_entry_t ENTRY_RESET = '{
        frame_count: 32'd0,
        start_id:    -32'sd1,
        end_id:      -32'sd1,
        good:        1'b1,
        cont:        1'b1,
        complete:    1'b1,
        status:      ST_PASS
    };

    // one input item
    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  channel;
        logic [7:0]  meta_type;
        logic [15:0] frame_type;
        logic [7:0]  item_size;
        logic [30:0] event_id;
    } item_t;

    // expected header values
    typedef struct packed {
        logic [7:0]  meta_type;
        logic [15:0] frame_type;
        logic [7:0]  item_size;
    } cfg_t;

    // shared unit operands and results
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } alu_req_t;

    typedef struct packed {
        logic signed [31:0] sum;
        logic               lt;
        logic               eq;
    } alu_rsp_t;

    // one result item
    typedef struct packed {
        logic               report_kind;
        logic [5:0]         channel_index;
        status_t            status;
        logic [31:0]        frame_count;
        logic signed [31:0] start_event;
        logic signed [31:0] end_event;
        logic               good_flag;
        logic               continuous_flag;
        logic               complete_flag;
        logic signed [31:0] gap_low;
        logic signed [31:0] gap_high;
        logic               last;
    } result_t;

endpackage

>>> hdl/fscc_ram.sv
// ----------------------------------------------------------------------------
// fscc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/fscc_alu.sv
// ----------------------------------------------------------------------------
// fscc_alu
// Shared add and signed compare unit: sum = a + b, compared against c.
// ----------------------------------------------------------------------------
module fscc_alu
    import fscc_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic signed [31:0] sum;

    // one adder, a signed less-than compare and an equality compare
    assign sum     = $signed(req.a) + $signed(req.b);
    assign rsp.sum = sum;
    assign rsp.lt  = $signed(sum) < $signed(req.c);
    assign rsp.eq  = (sum == req.c);

endmodule

>>> hdl/fscc_seq.sv
// ----------------------------------------------------------------------------
// fscc_seq
// Sequencer: per-channel read-modify-write for frame and absence items and the
// three finish walks over the channel table, driving the shared add and compare unit.
// ----------------------------------------------------------------------------
module fscc_seq
    import fscc_pkg::*;
#(
    parameter int CHANNELS = 42,
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  item_t              s_item,
    input  cfg_t               cfg,
    output logic [IDX_W-1:0]   ram_raddr,
    input  logic [ENTRY_W-1:0] ram_rdata,
    output logic               ram_we,
    output logic [IDX_W-1:0]   ram_waddr,
    output logic [ENTRY_W-1:0] ram_wdata,
    output alu_req_t           alu_req,
    input  alu_rsp_t           alu_rsp,
    input  logic               out_free,
    output logic               emit_valid,
    output result_t            emit_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
    localparam logic [6:0]       CH_LIMIT = 7'(CHANNELS);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     addr_reg, addr_next, adv_addr;
    logic                 rvalid_reg;
    logic [CHANNELS-1:0]  valid_reg;
    logic [CHANNELS-1:0]  start_flag_reg;
    logic                 end_flag_reg, end_flag_next;
    logic signed [31:0]   ref_s_reg, ref_s_next;
    logic signed [31:0]   ref_e_reg, ref_e_next;
    item_t                item_reg;

    channel_entry_t       entry, upd;
    logic                 in_range, is_last, hdr_ok, need_emit;
    logic                 sflag_set, sflags_clear;
    logic                 report_kind, last_flag;
    logic signed [31:0]   gap_low, gap_high;

    // table entry as seen: unwritten entries read as their reset value
    assign entry    = rvalid_reg ? channel_entry_t'(ram_rdata) : ENTRY_RESET;
    assign in_range = {1'b0, s_item.channel} < CH_LIMIT;
    assign is_last  = (addr_reg == LAST_IDX);
    assign adv_addr = is_last ? '0 : addr_reg + IDX_W'(1);
    assign hdr_ok   = (item_reg.meta_type == cfg.meta_type) &&
                      (item_reg.frame_type == cfg.frame_type) &&
                      (item_reg.item_size == cfg.item_size);

    assign ram_raddr = addr_next;
    assign ram_waddr = addr_reg;
    assign ram_wdata = ENTRY_W'(upd);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_item.kind == KIND_FINISH) begin
                        state_next = S_P1;
                    end else if (in_range && (s_item.kind == KIND_FRAME ||
                                              s_item.kind == KIND_ABSENT)) begin
                        state_next = S_FRAME;
                    end
                end
            end
            S_FRAME: begin
                if (!need_emit || out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_P1: begin
                if (is_last) begin
                    state_next = S_P2A;
                end
            end
            S_P2A: state_next = S_P2B;
            S_P2B: state_next = is_last ? S_P3A : S_P2A;
            S_P3A: state_next = S_P3B;
            S_P3B: begin
                if (out_free) begin
                    state_next = is_last ? S_IDLE : S_P3A;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath control and outputs
    always_comb begin
        s_ready       = 1'b0;
        ram_we        = 1'b0;
        upd           = entry;
        alu_req       = '0;
        need_emit     = 1'b0;
        emit_valid    = 1'b0;
        gap_low       = 32'sd0;
        gap_high      = -32'sd1;
        report_kind   = REPORT_FRAME;
        last_flag     = 1'b1;
        addr_next     = addr_reg;
        ref_s_next    = ref_s_reg;
        ref_e_next    = ref_e_reg;
        end_flag_next = end_flag_reg;
        sflag_set     = 1'b0;
        sflags_clear  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready   = 1'b1;
                addr_next = in_range ? s_item.channel[IDX_W-1:0] : '0;
                if (s_valid && s_item.kind == KIND_FINISH) begin
                    addr_next    = '0;
                    sflags_clear = 1'b1;
                end
            end
            S_FRAME: begin
                // prev + 1 == id
                alu_req.a = entry.end_id;
                alu_req.b = 32'sd1;
                alu_req.c = $signed({1'b0, item_reg.event_id});
                if (item_reg.kind == KIND_ABSENT) begin
                    upd.status = ST_BROKEN;
                    ram_we     = 1'b1;
                end else if (entry.status != ST_BROKEN) begin
                    if (!hdr_ok) begin
                        upd.good   = 1'b0;
                        upd.status = ST_BROKEN;
                        need_emit  = 1'b1;
                    end else begin
                        upd.frame_count = (entry.frame_count == '1) ?
                                          entry.frame_count : entry.frame_count + 32'd1;
                        upd.end_id = $signed({1'b0, item_reg.event_id});
                        if (entry.start_id == -32'sd1) begin
                            upd.start_id = $signed({1'b0, item_reg.event_id});
                        end else if (!alu_rsp.eq) begin
                            upd.cont   = 1'b0;
                            upd.status = ST_MISSING;
                            need_emit  = 1'b1;
                            gap_low    = entry.end_id;
                            gap_high   = entry.end_id;
                        end
                    end
                    ram_we     = !need_emit || out_free;
                    emit_valid = need_emit && out_free;
                end
            end
            S_P1: begin
                // minimum start over passing channels, seeded from channel 0
                alu_req.a = entry.start_id;
                alu_req.c = ref_s_reg;
                if (addr_reg == '0) begin
                    ref_s_next = entry.start_id;
                end else if (entry.status == ST_PASS && alu_rsp.lt) begin
                    ref_s_next = entry.start_id;
                end
                addr_next = adv_addr;
            end
            S_P2A: begin
                // start above reference on a passing channel
                alu_req.a = ref_s_reg;
                alu_req.c = entry.start_id;
                sflag_set = (entry.status == ST_PASS) && alu_rsp.lt;
            end
            S_P2B: begin
                // mark start mismatch, maximum end over channels still passing
                alu_req.a = ref_e_reg;
                alu_req.c = entry.end_id;
                if (start_flag_reg[addr_reg]) begin
                    upd.complete = 1'b0;
                    upd.status   = ST_INCOMPLETE;
                    ram_we       = 1'b1;
                end
                if (addr_reg == '0) begin
                    ref_e_next = entry.end_id;
                end else if (entry.status == ST_PASS && !start_flag_reg[addr_reg] &&
                             alu_rsp.lt) begin
                    ref_e_next = entry.end_id;
                end
                addr_next = adv_addr;
            end
            S_P3A: begin
                // end falls short of reference
                alu_req.a     = entry.end_id;
                alu_req.c     = ref_e_reg;
                end_flag_next = (entry.status == ST_PASS) && alu_rsp.lt;
            end
            S_P3B: begin
                // gap range and channel summary
                report_kind = REPORT_SUMMARY;
                last_flag   = is_last;
                if (start_flag_reg[addr_reg]) begin
                    alu_req.a = entry.start_id;
                    alu_req.b = -32'sd1;
                    gap_low   = ref_s_reg;
                    gap_high  = alu_rsp.sum;
                end else if (end_flag_reg) begin
                    alu_req.a    = entry.end_id;
                    alu_req.b    = 32'sd1;
                    gap_low      = alu_rsp.sum;
                    gap_high     = ref_e_reg;
                    upd.complete = 1'b0;
                    upd.status   = ST_INCOMPLETE;
                    ram_we       = out_free;
                end
                emit_valid = out_free;
                if (out_free) begin
                    addr_next = adv_addr;
                end
            end
            default: begin
                addr_next = addr_reg;
            end
        endcase
    end

    assign emit_data = '{
        report_kind:     report_kind,
        channel_index:   6'(addr_reg),
        status:          upd.status,
        frame_count:     upd.frame_count,
        start_event:     upd.start_id,
        end_event:       upd.end_id,
        good_flag:       upd.good,
        continuous_flag: upd.cont,
        complete_flag:   upd.complete,
        gap_low:         gap_low,
        gap_high:        gap_high,
        last:            last_flag
    };

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            addr_reg       <= '0;
            rvalid_reg     <= 1'b0;
            valid_reg      <= '0;
            start_flag_reg <= '0;
            end_flag_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            rvalid_reg   <= valid_reg[addr_next];
            end_flag_reg <= end_flag_next;
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (sflags_clear) begin
                start_flag_reg <= '0;
            end else if (sflag_set) begin
                start_flag_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ref_s_reg <= ref_s_next;
        ref_e_reg <= ref_e_next;
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_valid |-> out_free)
        else $error("result emitted into a full output slot");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !ram_we)
        else $error("table written while waiting for an item");

    a_finish_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.kind == KIND_FINISH)
        |=> (state_reg == S_P1 && addr_reg == '0))
        else $error("finish walk did not start at channel 0");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_P3B && start_flag_reg[addr_reg]) |-> !end_flag_reg)
        else $error("channel flagged on both start and end");

    a_last_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_valid && emit_data.report_kind == REPORT_SUMMARY && emit_data.last)
        |=> (state_reg == S_IDLE))
        else $error("sequencer busy after final summary");
`endif

endmodule

>>> hdl/frame_sequence_continuity_checker.sv
// ----------------------------------------------------------------------------
// frame_sequence_continuity_checker
// Per-channel frame header and event id continuity checker with summaries.
// ----------------------------------------------------------------------------
// A frame or absence item is accepted in a transfer cycle that also reads its
// channel entry from the table RAM; S_FRAME then does the read-modify-write
// through the shared add and compare unit, held while a result it raises
// waits for a free output register. An item that causes no result (unused
// kind, channel out of range) is dropped in its transfer cycle. The finish
// item runs the minimum start walk (S_P1), the start check and maximum end
// walk (S_P2A, S_P2B), and the end check and summary walk (S_P3A, S_P3B)
// over the channel table. A result waits in the output register until its
// transfer; while it waits, a further result holds the sequencer. The table
// needs no clearing pass after reset: per-entry valid bits supply reset values.
// ----------------------------------------------------------------------------
module frame_sequence_continuity_checker
    import fscc_pkg::*;
#(
    parameter int CHANNELS = 42
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [5:0]         s_channel,
    input  logic [7:0]         s_meta_type,
    input  logic [15:0]        s_frame_type,
    input  logic [7:0]         s_item_size,
    input  logic [30:0]        s_event_id,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_report_kind,
    output logic [5:0]         m_channel_index,
    output logic [1:0]         m_status,
    output logic [31:0]        m_frame_count,
    output logic signed [31:0] m_start_event,
    output logic signed [31:0] m_end_event,
    output logic               m_good_flag,
    output logic               m_continuous_flag,
    output logic               m_complete_flag,
    output logic signed [31:0] m_gap_low,
    output logic signed [31:0] m_gap_high,
    output logic               m_last,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    cfg_t               cfg_reg;
    item_t              s_item;
    logic [IDX_W-1:0]   ram_raddr, ram_waddr;
    logic [ENTRY_W-1:0] ram_rdata, ram_wdata;
    logic               ram_we;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;
    logic               out_free, emit_valid;
    result_t            emit_data, result_reg;
    logic               m_valid_reg, m_valid_next;

    assign s_item = '{
        kind:       s_kind,
        channel:    s_channel,
        meta_type:  s_meta_type,
        frame_type: s_frame_type,
        item_size:  s_item_size,
        event_id:   s_event_id
    };

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.meta_type  <= META_TYPE_RESET;
            cfg_reg.frame_type <= FRAME_TYPE_RESET;
            cfg_reg.item_size  <= ITEM_SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_META_TYPE:  cfg_reg.meta_type  <= cfg_wdata[7:0];
                CFG_FRAME_TYPE: cfg_reg.frame_type <= cfg_wdata;
                CFG_ITEM_SIZE:  cfg_reg.item_size  <= cfg_wdata[7:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // channel table
    fscc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared add and compare unit
    fscc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // sequencer
    fscc_seq #(
        .CHANNELS (CHANNELS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .cfg        (cfg_reg),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .alu_req    (alu_req),
        .alu_rsp    (alu_rsp),
        .out_free   (out_free),
        .emit_valid (emit_valid),
        .emit_data  (emit_data)
    );

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_valid) begin
            result_reg <= emit_data;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_report_kind     = result_reg.report_kind;
    assign m_channel_index   = result_reg.channel_index;
    assign m_status          = result_reg.status;
    assign m_frame_count     = result_reg.frame_count;
    assign m_start_event     = result_reg.start_event;
    assign m_end_event       = result_reg.end_event;
    assign m_good_flag       = result_reg.good_flag;
    assign m_continuous_flag = result_reg.continuous_flag;
    assign m_complete_flag   = result_reg.complete_flag;
    assign m_gap_low         = result_reg.gap_low;
    assign m_gap_high        = result_reg.gap_high;
    assign m_last            = result_reg.last;

endmodule
